[src/cbad_pkg.sv]
`timescale 1ns / 1ps

package cbad_pkg;

  // Field and counter widths
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 25;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 16;
  localparam int IMG_COLS_W = 13;
  localparam int WIN_W      = 5;
  localparam int WPOS_W     = 4;
  localparam int AREA_W     = 9;

  localparam int MAX_COLS = 4096;
  localparam int MAX_WIN  = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_ROWS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_COLS   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_ROWS   = 2'd3;

  localparam logic [IMG_COLS_W-1:0] IMAGE_COLS_RST = 13'd1024;
  localparam logic [ROW_W-1:0]      IMAGE_ROWS_RST = 16'd1024;
  localparam logic [WIN_W-1:0]      WIN_COLS_RST   = 5'd1;
  localparam logic [WIN_W-1:0]      WIN_ROWS_RST   = 5'd1;

  // Tile queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [ACC_W-1:0] sum_re;
    logic [ACC_W-1:0] sum_im;
    logic [COL_W-1:0] tcol;
    logic [ROW_W-1:0] trow;
    logic             last;
  } tile_t;

  typedef struct packed {
    logic full;
    logic afull;
    logic empty;
  } q_stat_t;

endpackage

[src/cbad_queue.sv]
`timescale 1ns / 1ps

module cbad_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cbad_pkg::tile_t push_data,
  input  logic            pop,
  output cbad_pkg::tile_t head,
  output cbad_pkg::q_stat_t stat
);

  cbad_pkg::tile_t                  mem_r [cbad_pkg::Q_DEPTH];
  logic [cbad_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [cbad_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [cbad_pkg::Q_CNT_W-1:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(cbad_pkg::Q_CNT_W-1){1'b0}}, push}
                         - {{(cbad_pkg::Q_CNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == cbad_pkg::Q_CNT_W'(cbad_pkg::Q_DEPTH));
  assign stat.afull = (count_r >= cbad_pkg::Q_CNT_W'(cbad_pkg::Q_DEPTH - 1));
  assign stat.empty = (count_r == '0);

endmodule

[src/cbad_front.sv]
`timescale 1ns / 1ps

module cbad_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbad_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cbad_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_re,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_im,
  input  cbad_pkg::q_stat_t                   q_stat,
  output logic                                q_push,
  output cbad_pkg::tile_t                     q_data,
  output logic [cbad_pkg::AREA_W-1:0]         area
);

  localparam int SW = cbad_pkg::SAMPLE_W;
  localparam int AW = cbad_pkg::ACC_W;

  // Registers
  logic [cbad_pkg::IMG_COLS_W-1:0] img_cols_r, img_cols_nxt;
  logic [cbad_pkg::ROW_W-1:0]      img_rows_r, img_rows_nxt;
  logic [cbad_pkg::WIN_W-1:0]      win_cols_r, win_cols_nxt;
  logic [cbad_pkg::WIN_W-1:0]      win_rows_r, win_rows_nxt;

  // Raster position
  logic [cbad_pkg::COL_W-1:0]  col_pos_r, col_pos_nxt, tcol_r, tcol_nxt;
  logic [cbad_pkg::ROW_W-1:0]  row_pos_r, row_pos_nxt, trow_r, trow_nxt;
  logic [cbad_pkg::WPOS_W-1:0] iwc_r, iwc_nxt, iwr_r, iwr_nxt;

  logic in_acc, cfg_we;
  logic last_col, last_row, col_end, row_end, wcol_wrap, wrow_wrap;

  // Accumulate stage
  logic                         st1_vld_r, st1_first_r, st1_emit_r, st1_last_r, st1_fwd_r;
  logic [cbad_pkg::COL_W-1:0]   st1_idx_r;
  logic [cbad_pkg::ROW_W-1:0]   st1_trow_r;
  logic [SW-1:0]                st1_re_r, st1_im_r;
  logic [AW-1:0]                rd_re_r, rd_im_r, fwd_re_r, fwd_im_r;
  logic [AW-1:0]                base_re, base_im, ext_re, ext_im, sum_re, sum_im;

  logic [AW-1:0] acc_re_mem [cbad_pkg::MAX_COLS];
  logic [AW-1:0] acc_im_mem [cbad_pkg::MAX_COLS];

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  // worst case: the item in the accumulate stage still pushes one tile
  assign in_stall  = q_stat.full || (st1_vld_r && st1_emit_r && q_stat.afull);
  assign in_acc    = in_valid && !in_stall;

  assign area = {4'b0000, win_cols_r} * {4'b0000, win_rows_r};

  // ---- configuration, with clamping ----
  always_comb begin
    img_cols_nxt = img_cols_r;
    img_rows_nxt = img_rows_r;
    win_cols_nxt = win_cols_r;
    win_rows_nxt = win_rows_r;
    if (cfg_we) begin
      case (cfg_addr)
        cbad_pkg::REG_IMAGE_COLS: begin
          if (cfg_wdata[cbad_pkg::IMG_COLS_W-1:0] == '0) begin
            img_cols_nxt = cbad_pkg::IMG_COLS_W'(1);
          end else if (cfg_wdata[cbad_pkg::IMG_COLS_W-1:0] >
                       cbad_pkg::IMG_COLS_W'(cbad_pkg::MAX_COLS)) begin
            img_cols_nxt = cbad_pkg::IMG_COLS_W'(cbad_pkg::MAX_COLS);
          end else begin
            img_cols_nxt = cfg_wdata[cbad_pkg::IMG_COLS_W-1:0];
          end
        end
        cbad_pkg::REG_IMAGE_ROWS: begin
          img_rows_nxt = (cfg_wdata[cbad_pkg::ROW_W-1:0] == '0) ?
                         cbad_pkg::ROW_W'(1) : cfg_wdata[cbad_pkg::ROW_W-1:0];
        end
        cbad_pkg::REG_WIN_COLS: begin
          if (cfg_wdata[cbad_pkg::WIN_W-1:0] == '0) begin
            win_cols_nxt = cbad_pkg::WIN_W'(1);
          end else if (cfg_wdata[cbad_pkg::WIN_W-1:0] >
                       cbad_pkg::WIN_W'(cbad_pkg::MAX_WIN)) begin
            win_cols_nxt = cbad_pkg::WIN_W'(cbad_pkg::MAX_WIN);
          end else begin
            win_cols_nxt = cfg_wdata[cbad_pkg::WIN_W-1:0];
          end
        end
        cbad_pkg::REG_WIN_ROWS: begin
          if (cfg_wdata[cbad_pkg::WIN_W-1:0] == '0) begin
            win_rows_nxt = cbad_pkg::WIN_W'(1);
          end else if (cfg_wdata[cbad_pkg::WIN_W-1:0] >
                       cbad_pkg::WIN_W'(cbad_pkg::MAX_WIN)) begin
            win_rows_nxt = cbad_pkg::WIN_W'(cbad_pkg::MAX_WIN);
          end else begin
            win_rows_nxt = cfg_wdata[cbad_pkg::WIN_W-1:0];
          end
        end
        default: begin
          img_cols_nxt = img_cols_r;
        end
      endcase
    end
  end

  // ---- position and tile classification ----
  always_comb begin
    last_col  = ({1'b0, col_pos_r} + 13'd1) >= img_cols_r;
    last_row  = ({1'b0, row_pos_r} + 17'd1) >= {1'b0, img_rows_r};
    wcol_wrap = ({1'b0, iwc_r} + 5'd1) >= win_cols_r;
    wrow_wrap = ({1'b0, iwr_r} + 5'd1) >= win_rows_r;
    col_end   = wcol_wrap || last_col;
    row_end   = wrow_wrap || last_row;

    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    tcol_nxt    = tcol_r;
    trow_nxt    = trow_r;
    iwc_nxt     = iwc_r;
    iwr_nxt     = iwr_r;
    if (cfg_we) begin
      col_pos_nxt = '0;
      row_pos_nxt = '0;
      tcol_nxt    = '0;
      trow_nxt    = '0;
      iwc_nxt     = '0;
      iwr_nxt     = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_pos_nxt = '0;
        tcol_nxt    = '0;
        iwc_nxt     = '0;
        if (last_row) begin
          row_pos_nxt = '0;
          trow_nxt    = '0;
          iwr_nxt     = '0;
        end else begin
          row_pos_nxt = row_pos_r + 1'b1;
          if (wrow_wrap) begin
            iwr_nxt  = '0;
            trow_nxt = trow_r + 1'b1;
          end else begin
            iwr_nxt = iwr_r + 1'b1;
          end
        end
      end else begin
        col_pos_nxt = col_pos_r + 1'b1;
        if (wcol_wrap) begin
          iwc_nxt  = '0;
          tcol_nxt = tcol_r + 1'b1;
        end else begin
          iwc_nxt = iwc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_cols_r <= cbad_pkg::IMAGE_COLS_RST;
      img_rows_r <= cbad_pkg::IMAGE_ROWS_RST;
      win_cols_r <= cbad_pkg::WIN_COLS_RST;
      win_rows_r <= cbad_pkg::WIN_ROWS_RST;
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      tcol_r     <= '0;
      trow_r     <= '0;
      iwc_r      <= '0;
      iwr_r      <= '0;
      st1_vld_r  <= 1'b0;
    end else begin
      img_cols_r <= img_cols_nxt;
      img_rows_r <= img_rows_nxt;
      win_cols_r <= win_cols_nxt;
      win_rows_r <= win_rows_nxt;
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      tcol_r     <= tcol_nxt;
      trow_r     <= trow_nxt;
      iwc_r      <= iwc_nxt;
      iwr_r      <= iwr_nxt;
      st1_vld_r  <= in_acc;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st1_first_r <= (iwc_r == '0) && (iwr_r == '0);
      st1_emit_r  <= col_end && row_end;
      st1_last_r  <= last_col && last_row;
      st1_idx_r   <= tcol_r;
      st1_trow_r  <= trow_r;
      st1_re_r    <= in_sample_re;
      st1_im_r    <= in_sample_im;
      // the entry being written this edge is not yet in the read data
      st1_fwd_r   <= st1_vld_r && (st1_idx_r == tcol_r);
    end
    if (st1_vld_r) begin
      fwd_re_r <= sum_re;
      fwd_im_r <= sum_im;
    end
  end

  // Accumulator store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (st1_vld_r) begin
      acc_re_mem[st1_idx_r] <= sum_re;
      acc_im_mem[st1_idx_r] <= sum_im;
    end
    if (in_acc) begin
      rd_re_r <= acc_re_mem[tcol_r];
      rd_im_r <= acc_im_mem[tcol_r];
    end
  end

  always_comb begin
    ext_re  = {{(AW-SW){st1_re_r[SW-1]}}, st1_re_r};
    ext_im  = {{(AW-SW){st1_im_r[SW-1]}}, st1_im_r};
    base_re = st1_fwd_r ? fwd_re_r : rd_re_r;
    base_im = st1_fwd_r ? fwd_im_r : rd_im_r;
    sum_re  = st1_first_r ? ext_re : base_re + ext_re;
    sum_im  = st1_first_r ? ext_im : base_im + ext_im;
  end

  assign q_push        = st1_vld_r && st1_emit_r;
  assign q_data.sum_re = sum_re;
  assign q_data.sum_im = sum_im;
  assign q_data.tcol   = st1_idx_r;
  assign q_data.trow   = st1_trow_r;
  assign q_data.last   = st1_last_r;

endmodule

[src/cbad_back.sv]
`timescale 1ns / 1ps

module cbad_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cbad_pkg::q_stat_t                    q_stat,
  input  cbad_pkg::tile_t                      q_head,
  output logic                                 q_pop,
  input  logic [cbad_pkg::AREA_W-1:0]          area,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_re,
  output logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_im,
  output logic [cbad_pkg::COL_W-1:0]           out_col,
  output logic [cbad_pkg::ROW_W-1:0]           out_row,
  output logic                                 out_last_of_image
);

  localparam int AW  = cbad_pkg::ACC_W;
  localparam int DW  = cbad_pkg::AREA_W;
  localparam int CNT_W = $clog2(AW);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // dividend shifts out as quotient bits shift in
  logic [AW-1:0] dq_re_r, dq_re_nxt, dq_im_r, dq_im_nxt;
  logic [DW-1:0] rem_re_r, rem_re_nxt, rem_im_r, rem_im_nxt;
  logic          neg_re_r, neg_im_r;
  logic [cbad_pkg::COL_W-1:0] tcol_r;
  logic [cbad_pkg::ROW_W-1:0] trow_r;
  logic                       last_r;

  logic [DW:0]   sh_re, sh_im;
  logic          ge_re, ge_im;
  logic [AW-1:0] q_re, q_im;
  logic          out_free, load_out;
  logic          out_valid_r, out_valid_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign load_out = (state_r == S_DONE) && out_free;

  always_comb begin
    sh_re = {rem_re_r, dq_re_r[AW-1]};
    sh_im = {rem_im_r, dq_im_r[AW-1]};
    ge_re = sh_re >= {1'b0, area};
    ge_im = sh_im >= {1'b0, area};

    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    dq_re_nxt  = dq_re_r;
    dq_im_nxt  = dq_im_r;
    rem_re_nxt = rem_re_r;
    rem_im_nxt = rem_im_r;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          dq_re_nxt  = q_head.sum_re[AW-1] ? (~q_head.sum_re + 1'b1) : q_head.sum_re;
          dq_im_nxt  = q_head.sum_im[AW-1] ? (~q_head.sum_im + 1'b1) : q_head.sum_im;
          rem_re_nxt = '0;
          rem_im_nxt = '0;
          cnt_nxt    = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        rem_re_nxt = ge_re ? DW'(sh_re - {1'b0, area}) : sh_re[DW-1:0];
        rem_im_nxt = ge_im ? DW'(sh_im - {1'b0, area}) : sh_im[DW-1:0];
        dq_re_nxt  = {dq_re_r[AW-2:0], ge_re};
        dq_im_nxt  = {dq_im_r[AW-2:0], ge_im};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(AW - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_re_r  <= dq_re_nxt;
    dq_im_r  <= dq_im_nxt;
    rem_re_r <= rem_re_nxt;
    rem_im_r <= rem_im_nxt;
    if (q_pop) begin
      neg_re_r <= q_head.sum_re[AW-1];
      neg_im_r <= q_head.sum_im[AW-1];
      tcol_r   <= q_head.tcol;
      trow_r   <= q_head.trow;
      last_r   <= q_head.last;
    end
  end

  // restore sign: magnitude division truncates toward zero
  assign q_re = neg_re_r ? (~dq_re_r + 1'b1) : dq_re_r;
  assign q_im = neg_im_r ? (~dq_im_r + 1'b1) : dq_im_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_avg_re        <= q_re[cbad_pkg::SAMPLE_W-1:0];
      out_avg_im        <= q_im[cbad_pkg::SAMPLE_W-1:0];
      out_col           <= tcol_r;
      out_row           <= trow_r;
      out_last_of_image <= last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/complex_block_average_decimator_core.sv]
`timescale 1ns / 1ps

// Channel | Ports                                        | Beat taken when
// --------+----------------------------------------------+--------------------------
// in      | in_valid, in_stall, in_sample_re/_im         | in_valid  & !in_stall
// out     | out_valid, out_stall, out_avg_re/_im,        | out_valid & !out_stall
//         | out_col, out_row, out_last_of_image          |
// cfg     | cfg_valid, cfg_ready, cfg_addr, cfg_wdata    | cfg_valid & cfg_ready
//
// Front end takes one sample beat per cycle while in_stall is low (registered
// read of the column accumulator, then add and write-back in the accumulate
// stage, with forwarding for back-to-back hits). For each finished tile the back
// end loads it, runs 25 steps of the shared bit-serial divider (re and im lanes
// side by side) and hands off to the output register; it takes the next tile
// only once that hand-off is done. A 4-entry tile queue lets the front run ahead.
// Reset: synchronous rst_n; registers return to 1024 x 1024, window 1 x 1.
// Accumulator RAM has no reset and no clearing pass.
// in_stall rises when the tile queue is full, or almost full with a tile push in flight.

module complex_block_average_decimator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cbad_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [cbad_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_re,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_im,
  // tile results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_re,
  output logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_im,
  output logic [cbad_pkg::COL_W-1:0]           out_col,
  output logic [cbad_pkg::ROW_W-1:0]           out_row,
  output logic                                 out_last_of_image
);

  cbad_pkg::q_stat_t           q_stat;
  cbad_pkg::tile_t             q_wdata;
  cbad_pkg::tile_t             q_head;
  logic                        q_push;
  logic                        q_pop;
  logic [cbad_pkg::AREA_W-1:0] area;

  // Front: register file, raster counters, accumulator RAM
  cbad_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .area         (area)
  );

  // Finished tile sums awaiting division
  cbad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Back: divide by window area, output register
  cbad_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .area              (area),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_avg_re        (out_avg_re),
    .out_avg_im        (out_avg_im),
    .out_col           (out_col),
    .out_row           (out_row),
    .out_last_of_image (out_last_of_image)
  );

  // Tile queue must never be pushed when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("tile queue overflow");

  // Back end only pops a filled queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("tile queue underflow");

  // A full queue holds off the sample channel
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> in_stall)
    else $error("sample taken with tile queue full");

endmodule

[sim/box_average_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the box average decimator, keeps its own
// copy of the tiling state and accumulators, and checks every result beat
// against the oldest awaited tile.
module box_average_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [cbad_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [cbad_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_re,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_im,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_re,
  input  logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_im,
  input  logic [cbad_pkg::COL_W-1:0]           out_col,
  input  logic [cbad_pkg::ROW_W-1:0]           out_row,
  input  logic                                 out_last_of_image,
  output int                                   mismatches,
  output int                                   tiles_due
);

  typedef struct packed {
    logic [cbad_pkg::SAMPLE_W-1:0] avg_re;
    logic [cbad_pkg::SAMPLE_W-1:0] avg_im;
    logic [cbad_pkg::COL_W-1:0]    col;
    logic [cbad_pkg::ROW_W-1:0]    row;
    logic                          last;
  } tile_avg_t;

  tile_avg_t awaited_tiles[$];
  tile_avg_t want;

  // settings as the block sees them, after saturation
  int img_cols, img_rows, win_c, win_r;
  // raster position and position inside the tile
  int col_pos, row_pos, wcol, wrow;
  longint sum_re [cbad_pkg::MAX_COLS];
  longint sum_im [cbad_pkg::MAX_COLS];

  function automatic int saturate_setting(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic check_field(input string what, input longint exp, input longint got);
    if (exp != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp, got);
      mismatches++;
    end
  endtask

  task automatic absorb_sample(input logic signed [cbad_pkg::SAMPLE_W-1:0] re,
                               input logic signed [cbad_pkg::SAMPLE_W-1:0] im);
    int tcol, trow;
    bit last_col, last_row, col_end, row_end;
    longint area;
    tile_avg_t t;
    tcol = col_pos / win_c;
    trow = row_pos / win_r;
    last_col = (col_pos + 1 >= img_cols);
    last_row = (row_pos + 1 >= img_rows);
    col_end = (wcol + 1 >= win_c) || last_col;
    row_end = (wrow + 1 >= win_r) || last_row;

    // first beat of a tile overwrites the column's sums
    if (wcol == 0 && wrow == 0) begin
      sum_re[tcol] = re;
      sum_im[tcol] = im;
    end else begin
      sum_re[tcol] += re;
      sum_im[tcol] += im;
    end

    if (col_end && row_end) begin
      area = win_c * win_r;          // full area, even for cut-off tiles
      t.avg_re = cbad_pkg::SAMPLE_W'(sum_re[tcol] / area);
      t.avg_im = cbad_pkg::SAMPLE_W'(sum_im[tcol] / area);
      t.col    = cbad_pkg::COL_W'(tcol);
      t.row    = cbad_pkg::ROW_W'(trow);
      t.last   = last_col && last_row;
      awaited_tiles.push_back(t);
    end

    if (last_col) begin
      col_pos = 0;
      wcol    = 0;
      if (last_row) begin
        row_pos = 0;
        wrow    = 0;
      end else begin
        row_pos++;
        wrow = (wrow + 1 >= win_r) ? 0 : wrow + 1;
      end
    end else begin
      col_pos++;
      wcol = (wcol + 1 >= win_c) ? 0 : wcol + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_tiles.delete();
      mismatches = 0;
      img_cols = int'(cbad_pkg::IMAGE_COLS_RST);
      img_rows = int'(cbad_pkg::IMAGE_ROWS_RST);
      win_c    = int'(cbad_pkg::WIN_COLS_RST);
      win_r    = int'(cbad_pkg::WIN_ROWS_RST);
      col_pos  = 0;
      row_pos  = 0;
      wcol     = 0;
      wrow     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_tiles.size() == 0) begin
          $display("%0t: unexpected tile beat, col %0d row %0d", $time, out_col, out_row);
          mismatches++;
        end else begin
          want = awaited_tiles.pop_front();
          check_field("avg_re", $signed(want.avg_re), out_avg_re);
          check_field("avg_im", $signed(want.avg_im), out_avg_im);
          check_field("out_col", want.col, out_col);
          check_field("out_row", want.row, out_row);
          check_field("last_of_image", want.last, out_last_of_image);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          cbad_pkg::REG_IMAGE_COLS:
            img_cols = saturate_setting(int'(cfg_wdata[cbad_pkg::IMG_COLS_W-1:0]),
                                        cbad_pkg::MAX_COLS);
          cbad_pkg::REG_IMAGE_ROWS:
            img_rows = saturate_setting(int'(cfg_wdata[cbad_pkg::ROW_W-1:0]), 65535);
          cbad_pkg::REG_WIN_COLS:
            win_c = saturate_setting(int'(cfg_wdata[cbad_pkg::WIN_W-1:0]),
                                     cbad_pkg::MAX_WIN);
          cbad_pkg::REG_WIN_ROWS:
            win_r = saturate_setting(int'(cfg_wdata[cbad_pkg::WIN_W-1:0]),
                                     cbad_pkg::MAX_WIN);
          default: ;
        endcase
        // any write restarts the image
        col_pos = 0;
        row_pos = 0;
        wcol    = 0;
        wrow    = 0;
      end

      if (in_valid && !in_stall)
        absorb_sample(in_sample_re, in_sample_im);
    end
    tiles_due = awaited_tiles.size();
  end

endmodule

[sim/complex_block_average_decimator_core_test.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the box average decimator. All prediction and
// comparison lives in box_average_checker; this module only drives beats,
// paces both sides and decides pass or fail.
module complex_block_average_decimator_core_test;

  localparam int TOTAL_ITEMS   = 1950;  // stop feeding once this many beats are in
  localparam int CALM_AFTER    = 1700;  // no idling on either side past this point
  localparam int SETTLE_CYCLES = 40;    // front pipe drains well within this
  localparam int STALL_LIMIT   = 3000;  // cycles without any beat before giving up

  typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_TINY, FILL_MAX, FILL_MIN} fill_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [cbad_pkg::CFG_ADDR_W-1:0]      cfg_addr = '0;
  logic [cbad_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_re = '0;
  logic signed [cbad_pkg::SAMPLE_W-1:0] in_sample_im = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_re;
  logic signed [cbad_pkg::SAMPLE_W-1:0] out_avg_im;
  logic [cbad_pkg::COL_W-1:0]           out_col;
  logic [cbad_pkg::ROW_W-1:0]           out_row;
  logic                                 out_last_of_image;

  int mismatches;
  int tiles_due;

  int items_sent = 0;
  bit calm = 1'b0;        // set near the end: both sides run flat out
  bit in_gappy = 1'b0;    // per phase: does the sender idle at all
  int stall_left = 0;
  int quiet_left = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  complex_block_average_decimator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_re      (in_sample_re),
    .in_sample_im      (in_sample_im),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_avg_re        (out_avg_re),
    .out_avg_im        (out_avg_im),
    .out_col           (out_col),
    .out_row           (out_row),
    .out_last_of_image (out_last_of_image)
  );

  box_average_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_re      (in_sample_re),
    .in_sample_im      (in_sample_im),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_avg_re        (out_avg_re),
    .out_avg_im        (out_avg_im),
    .out_col           (out_col),
    .out_row           (out_row),
    .out_last_of_image (out_last_of_image),
    .mismatches        (mismatches),
    .tiles_due         (tiles_due)
  );

  // Result side back-pressure: bursts of stalled cycles, broken up by
  // quiet stretches in which every result beat goes straight through.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet_left > 0) begin
      out_stall  <= 1'b0;
      quiet_left <= quiet_left - 1;
    end else if ($urandom_range(0, 29) == 0) begin
      out_stall  <= 1'b0;
      quiet_left <= $urandom_range(30, 150);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [cbad_pkg::SAMPLE_W-1:0] draw_sample(input fill_t fill);
    case (fill)
      FILL_EXTREME: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      FILL_TINY:    return 16'($urandom_range(0, 8) - 4);  // truncation towards zero
      FILL_MAX:     return 16'h7FFF;                       // accumulator headroom
      FILL_MIN:     return 16'h8000;
      default:      return ($urandom_range(0, 7) == 0) ? draw_sample(FILL_EXTREME)
                                                       : 16'($urandom);
    endcase
  endfunction

  // Called and returns at a falling edge; valid is left high so that
  // back-to-back beats need no extra edge on it.
  task automatic send_sample(input logic [cbad_pkg::SAMPLE_W-1:0] re,
                             input logic [cbad_pkg::SAMPLE_W-1:0] im);
    int gap;
    if (!calm && in_gappy && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_re <= re;
    in_sample_im <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
    @(negedge clk);
  endtask

  // Valid stays high between consecutive writes; caller drops it afterwards.
  task automatic write_reg(input logic [cbad_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [cbad_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for every awaited tile, then give the front pipe time to swallow
  // any trailing beats that finish no tile.
  task automatic settle();
    in_valid <= 1'b0;
    while (tiles_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [cbad_pkg::CFG_DATA_W-1:0] cols_w,
                           input logic [cbad_pkg::CFG_DATA_W-1:0] rows_w,
                           input logic [cbad_pkg::CFG_DATA_W-1:0] wcol_w,
                           input logic [cbad_pkg::CFG_DATA_W-1:0] wrow_w,
                           input logic [3:0] which, input int n_items, input fill_t fill);
    if (which[0]) write_reg(cbad_pkg::REG_IMAGE_COLS, cols_w);
    if (which[1]) write_reg(cbad_pkg::REG_IMAGE_ROWS, rows_w);
    if (which[2]) write_reg(cbad_pkg::REG_WIN_COLS, wcol_w);
    if (which[3]) write_reg(cbad_pkg::REG_WIN_ROWS, wrow_w);
    cfg_valid <= 1'b0;
    in_gappy = ($urandom_range(0, 3) != 0);
    repeat (n_items) send_sample(draw_sample(fill), draw_sample(fill));
    settle();
  endtask

  initial begin
    int cols, rows, wc, wr, n;
    logic [3:0] which;
    fill_t fill;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings (1 x 1 window) pass each sample straight
    // through, so the field extremes come back unchanged.
    in_gappy = 1'b1;
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    settle();

    // 5 x 3 image, 2 x 2 window: cut-off tiles on the right and bottom
    // edges, end of image on the last beat.
    write_reg(cbad_pkg::REG_IMAGE_COLS, 16'd5);
    write_reg(cbad_pkg::REG_IMAGE_ROWS, 16'd3);
    write_reg(cbad_pkg::REG_WIN_COLS, 16'd2);
    write_reg(cbad_pkg::REG_WIN_ROWS, 16'd2);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 15; i++)
      send_sample(draw_sample(i[0] ? FILL_TINY : FILL_EXTREME),
                  draw_sample(i[1] ? FILL_EXTREME : FILL_TINY));
    settle();

    // Break off an image part-way, then a zero window height (counts as 1)
    // restarts it from the top-left corner.
    repeat (3) send_sample(draw_sample(FILL_TINY), draw_sample(FILL_TINY));
    settle();
    write_reg(cbad_pkg::REG_WIN_ROWS, 16'd0);
    cfg_valid <= 1'b0;
    repeat (3) send_sample(draw_sample(FILL_TINY), draw_sample(FILL_TINY));
    settle();

    // Corner settings: widest row (saturated from an all-ones write) with a
    // saturated 16 x 16 window over a one-row image, then the tallest image
    // one column wide, then full tiles at both extremes of the sample range.
    run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFE0 | 16'd31, 4'hF, 160, FILL_RANDOM);
    run_phase(16'h0000, 16'hFFFF, 16'd1, 16'd16, 4'hF, 64, FILL_EXTREME);
    run_phase(16'd16, 16'd16, 16'd16, 16'd16, 4'hF, 256, FILL_MAX);
    run_phase(16'd16, 16'd16, 16'd16, 16'd16, 4'hF, 256, FILL_MIN);

    // Random phases: mostly whole images at small sizes, some cut short,
    // some with only part of the settings rewritten.
    while (items_sent < TOTAL_ITEMS) begin
      cols = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      rows = $urandom_range(1, 8);
      wc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
      wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
      n = cols * rows * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > 240) n = 240;
      if (n > TOTAL_ITEMS - items_sent) n = TOTAL_ITEMS - items_sent;
      which = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'hF;
      fill = ($urandom_range(0, 9) < 6) ? FILL_RANDOM : fill_t'($urandom_range(1, 4));
      run_phase({3'($urandom), 13'(cols)}, 16'(rows),
                {11'($urandom), 5'(wc)}, {11'($urandom), 5'(wr)}, which, n, fill);
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
